// ===== rtl/core/csov_pkg.sv =====
// shared types and widths for the collinear segment overlap pipeline
`default_nettype none
package csov_pkg;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 8;
   localparam int OUT_BITS   = COORD_BITS + FRAC_BITS;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int LEN_BITS   = 2 * COORD_BITS + 1;
   localparam int PROJ_BITS  = 2 * COORD_BITS + 2;
   localparam int PROD_BITS  = COORD_BITS + PROJ_BITS - 1;
   localparam int NUM_BITS   = PROD_BITS + FRAC_BITS;
   localparam int QUOT_BITS  = OUT_BITS;
   localparam int MAP_LAT    = QUOT_BITS + 2;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] seg_start_x;
      logic signed [COORD_BITS-1:0] seg_start_y;
      logic signed [COORD_BITS-1:0] seg_end_x;
      logic signed [COORD_BITS-1:0] seg_end_y;
      logic signed [COORD_BITS-1:0] first_part_start_x;
      logic signed [COORD_BITS-1:0] first_part_start_y;
      logic signed [COORD_BITS-1:0] first_part_end_x;
      logic signed [COORD_BITS-1:0] first_part_end_y;
      logic signed [COORD_BITS-1:0] second_part_start_x;
      logic signed [COORD_BITS-1:0] second_part_start_y;
      logic signed [COORD_BITS-1:0] second_part_end_x;
      logic signed [COORD_BITS-1:0] second_part_end_y;
   } seg_req_type;

   typedef struct packed {
      logic                       overlaps;
      logic signed [OUT_BITS-1:0] overlap_start_x;
      logic signed [OUT_BITS-1:0] overlap_start_y;
      logic signed [OUT_BITS-1:0] overlap_end_x;
      logic signed [OUT_BITS-1:0] overlap_end_y;
   } seg_rsp_type;

   // one coordinate to map back: |v|*|t|, its sign, the start and the length
   typedef struct packed {
      logic                         neg;
      logic signed [COORD_BITS-1:0] s;
      logic [PROD_BITS-1:0]         prod;
      logic [LEN_BITS-1:0]          len;
   } map_in_type;

endpackage
`default_nettype wire

// ===== rtl/core/csov_map.sv =====
// pipelined floor division of one mapped coordinate, offset and saturation
`default_nettype none
module csov_map
   import csov_pkg::*;
(
   input  wire logic                       clock,
   input  wire map_in_type                 map_in,
   output logic signed [OUT_BITS-1:0]      coord
);

   localparam int HIGH_BITS = NUM_BITS - QUOT_BITS;
   localparam int VAL_BITS  = QUOT_BITS + 2;
   localparam logic signed [VAL_BITS-1:0] SAT_HI = VAL_BITS'((64'sd1 <<< (OUT_BITS - 1)) - 1);
   localparam logic signed [VAL_BITS-1:0] SAT_LO = VAL_BITS'(-(64'sd1 <<< (OUT_BITS - 1)));

   logic [NUM_BITS-1:0]  num;
   logic [HIGH_BITS-1:0] num_high;

   logic [LEN_BITS-1:0]          rem_ff  [QUOT_BITS+1];
   logic [QUOT_BITS-1:0]         low_ff  [QUOT_BITS+1];
   logic [QUOT_BITS-1:0]         quot_ff [QUOT_BITS+1];
   logic [LEN_BITS-1:0]          len_ff  [QUOT_BITS+1];
   logic signed [COORD_BITS-1:0] s_ff    [QUOT_BITS+1];
   logic                         neg_ff  [QUOT_BITS+1];
   logic                         ovf_ff  [QUOT_BITS+1];

   logic [LEN_BITS-1:0]  rem_in  [QUOT_BITS];
   logic [QUOT_BITS-1:0] quot_in [QUOT_BITS];

   logic [VAL_BITS-1:0]        mag_val;
   logic signed [VAL_BITS-1:0] val;
   logic signed [VAL_BITS-1:0] sum;
   logic signed [OUT_BITS-1:0] coord_in;
   logic signed [OUT_BITS-1:0] coord_ff;

   assign num      = NUM_BITS'(map_in.prod) << FRAC_BITS;
   assign num_high = num[NUM_BITS-1:QUOT_BITS];

   // one restoring step per stage, quotient msb first
   always_comb begin
      for (int i = 0; i < QUOT_BITS; i++) begin
         logic [LEN_BITS:0] trial;
         logic              ge;
         trial = {rem_ff[i], low_ff[i][QUOT_BITS-1]};
         ge    = trial >= {1'b0, len_ff[i]};
         rem_in[i]  = ge ? LEN_BITS'(trial - {1'b0, len_ff[i]}) : LEN_BITS'(trial);
         quot_in[i] = {quot_ff[i][QUOT_BITS-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      // quotient too large for the output range saturates
      rem_ff[0]  <= num_high;
      low_ff[0]  <= num[QUOT_BITS-1:0];
      quot_ff[0] <= '0;
      len_ff[0]  <= map_in.len;
      s_ff[0]    <= map_in.s;
      neg_ff[0]  <= map_in.neg;
      ovf_ff[0]  <= num_high >= map_in.len;
      for (int i = 0; i < QUOT_BITS; i++) begin
         rem_ff[i+1]  <= rem_in[i];
         low_ff[i+1]  <= low_ff[i] << 1;
         quot_ff[i+1] <= quot_in[i];
         len_ff[i+1]  <= len_ff[i];
         s_ff[i+1]    <= s_ff[i];
         neg_ff[i+1]  <= neg_ff[i];
         ovf_ff[i+1]  <= ovf_ff[i];
      end
   end

   always_comb begin
      // floor of a negative quotient rounds away when there is a remainder
      mag_val = VAL_BITS'(quot_ff[QUOT_BITS])
              + VAL_BITS'(neg_ff[QUOT_BITS] && (rem_ff[QUOT_BITS] != '0));
      val = neg_ff[QUOT_BITS] ? -$signed(mag_val) : $signed(mag_val);
      sum = val + (VAL_BITS'(s_ff[QUOT_BITS]) <<< FRAC_BITS);
      if (ovf_ff[QUOT_BITS]) begin
         coord_in = neg_ff[QUOT_BITS] ? OUT_BITS'(SAT_LO) : OUT_BITS'(SAT_HI);
      end else if (sum > SAT_HI) begin
         coord_in = OUT_BITS'(SAT_HI);
      end else if (sum < SAT_LO) begin
         coord_in = OUT_BITS'(SAT_LO);
      end else begin
         coord_in = OUT_BITS'(sum);
      end
   end

   always_ff @(posedge clock) begin
      coord_ff <= coord_in;
   end

   assign coord = coord_ff;

endmodule
`default_nettype wire

// ===== rtl/core/collinear_segment_overlap.sv =====
// top level: projection, overlap test and four mapping dividers
// One item may start in every clock cycle; busy is high only during reset and the
// cycle after it. A result is on rsp_item, marked by rsp_valid for one cycle. Its item
// passes through six stages of differences, products, projection sums, ordering,
// overlap test and the mapping multiply, then a 24-step restoring divider (one
// quotient bit per stage) with its setup and rounding stages, then the output
// register. Results come out in the order items went in and cannot be held off,
// so the receiver must take each one in its cycle.
`default_nettype none
module collinear_segment_overlap
   import csov_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire seg_req_type req_item,
   output logic             rsp_valid,
   output seg_rsp_type      rsp_item
);

   localparam int PIPE_LAT = 6 + MAP_LAT + 1;

   logic busy_ff;
   logic accept;

   // stage 1: differences
   logic                        v1_ff;
   logic signed [DIFF_BITS-1:0] vx1_ff, vy1_ff;
   logic signed [DIFF_BITS-1:0] dx1_ff [4];
   logic signed [DIFF_BITS-1:0] dy1_ff [4];
   logic signed [COORD_BITS-1:0] sx1_ff, sy1_ff;
   logic signed [COORD_BITS-1:0] px_in [4];
   logic signed [COORD_BITS-1:0] py_in [4];

   // stage 2: products
   logic                         v2_ff;
   logic signed [PROJ_BITS-1:0]  sqx2_ff, sqy2_ff;
   logic signed [PROJ_BITS-1:0]  mx2_ff [4];
   logic signed [PROJ_BITS-1:0]  my2_ff [4];
   logic signed [DIFF_BITS-1:0]  vx2_ff, vy2_ff;
   logic signed [COORD_BITS-1:0] sx2_ff, sy2_ff;

   // stage 3: projections
   logic                         v3_ff;
   logic [LEN_BITS-1:0]          len3_ff;
   logic signed [PROJ_BITS-1:0]  t3_ff [4];
   logic signed [DIFF_BITS-1:0]  vx3_ff, vy3_ff;
   logic signed [COORD_BITS-1:0] sx3_ff, sy3_ff;

   // stage 4: ordered ends
   logic                         v4_ff;
   logic                         zero4_ff;
   logic [LEN_BITS-1:0]          len4_ff;
   logic signed [PROJ_BITS-1:0]  lo1_4_ff, hi1_4_ff, lo2_4_ff, hi2_4_ff;
   logic signed [DIFF_BITS-1:0]  vx4_ff, vy4_ff;
   logic signed [COORD_BITS-1:0] sx4_ff, sy4_ff;

   // stage 5: overlap test and bounds
   logic                         v5_ff;
   logic                         ovl5_ff;
   logic [LEN_BITS-1:0]          len5_ff;
   logic signed [PROJ_BITS-1:0]  tlo5_ff, thi5_ff;
   logic signed [DIFF_BITS-1:0]  vx5_ff, vy5_ff;
   logic signed [COORD_BITS-1:0] sx5_ff, sy5_ff;

   // stage 6: mapping products
   logic       v6_ff;
   logic       ovl6_ff;
   map_in_type map_in [4];
   map_in_type map6_ff [4];
   logic signed [OUT_BITS-1:0] coord [4];

   logic [MAP_LAT-1:0] vdly_ff;
   logic [MAP_LAT-1:0] odly_ff;

   logic        rsp_valid_ff;
   seg_rsp_type rsp_ff;
   seg_rsp_type rsp_in;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   always_comb begin
      px_in[0] = req_item.first_part_start_x;
      py_in[0] = req_item.first_part_start_y;
      px_in[1] = req_item.first_part_end_x;
      py_in[1] = req_item.first_part_end_y;
      px_in[2] = req_item.second_part_start_x;
      py_in[2] = req_item.second_part_start_y;
      px_in[3] = req_item.second_part_end_x;
      py_in[3] = req_item.second_part_end_y;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         vdly_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= accept;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         v6_ff        <= v5_ff;
         vdly_ff      <= {vdly_ff[MAP_LAT-2:0], v6_ff};
         rsp_valid_ff <= vdly_ff[MAP_LAT-1];
      end
   end

   // payload
   always_ff @(posedge clock) begin
      sx1_ff <= req_item.seg_start_x;
      sy1_ff <= req_item.seg_start_y;
      vx1_ff <= DIFF_BITS'(req_item.seg_end_x) - DIFF_BITS'(req_item.seg_start_x);
      vy1_ff <= DIFF_BITS'(req_item.seg_end_y) - DIFF_BITS'(req_item.seg_start_y);
      for (int k = 0; k < 4; k++) begin
         dx1_ff[k] <= DIFF_BITS'(px_in[k]) - DIFF_BITS'(req_item.seg_start_x);
         dy1_ff[k] <= DIFF_BITS'(py_in[k]) - DIFF_BITS'(req_item.seg_start_y);
      end

      sqx2_ff <= PROJ_BITS'(vx1_ff) * PROJ_BITS'(vx1_ff);
      sqy2_ff <= PROJ_BITS'(vy1_ff) * PROJ_BITS'(vy1_ff);
      for (int k = 0; k < 4; k++) begin
         mx2_ff[k] <= PROJ_BITS'(dx1_ff[k]) * PROJ_BITS'(vx1_ff);
         my2_ff[k] <= PROJ_BITS'(dy1_ff[k]) * PROJ_BITS'(vy1_ff);
      end
      vx2_ff <= vx1_ff;
      vy2_ff <= vy1_ff;
      sx2_ff <= sx1_ff;
      sy2_ff <= sy1_ff;

      len3_ff <= LEN_BITS'(sqx2_ff + sqy2_ff);
      for (int k = 0; k < 4; k++) begin
         t3_ff[k] <= mx2_ff[k] + my2_ff[k];
      end
      vx3_ff <= vx2_ff;
      vy3_ff <= vy2_ff;
      sx3_ff <= sx2_ff;
      sy3_ff <= sy2_ff;

      zero4_ff <= len3_ff == '0;
      len4_ff  <= len3_ff;
      lo1_4_ff <= (t3_ff[0] < t3_ff[1]) ? t3_ff[0] : t3_ff[1];
      hi1_4_ff <= (t3_ff[0] < t3_ff[1]) ? t3_ff[1] : t3_ff[0];
      lo2_4_ff <= (t3_ff[2] < t3_ff[3]) ? t3_ff[2] : t3_ff[3];
      hi2_4_ff <= (t3_ff[2] < t3_ff[3]) ? t3_ff[3] : t3_ff[2];
      vx4_ff   <= vx3_ff;
      vy4_ff   <= vy3_ff;
      sx4_ff   <= sx3_ff;
      sy4_ff   <= sy3_ff;

      // intervals that only touch do not overlap
      ovl5_ff <= !zero4_ff && !(lo1_4_ff >= hi2_4_ff || hi1_4_ff <= lo2_4_ff);
      tlo5_ff <= (lo1_4_ff > lo2_4_ff) ? lo1_4_ff : lo2_4_ff;
      thi5_ff <= (hi1_4_ff < hi2_4_ff) ? hi1_4_ff : hi2_4_ff;
      len5_ff <= len4_ff;
      vx5_ff  <= vx4_ff;
      vy5_ff  <= vy4_ff;
      sx5_ff  <= sx4_ff;
      sy5_ff  <= sy4_ff;

      ovl6_ff <= ovl5_ff;
      for (int k = 0; k < 4; k++) begin
         map6_ff[k] <= map_in[k];
      end

      odly_ff <= {odly_ff[MAP_LAT-2:0], ovl6_ff};
      rsp_ff  <= rsp_in;
   end

   // magnitudes and signs for the four mapped coordinates
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         logic signed [DIFF_BITS-1:0] v;
         logic signed [PROJ_BITS-1:0] t;
         logic signed [COORD_BITS-1:0] s;
         logic [COORD_BITS-1:0]        av;
         logic [PROJ_BITS-2:0]         at;
         v  = (k % 2 == 0) ? vx5_ff : vy5_ff;
         s  = (k % 2 == 0) ? sx5_ff : sy5_ff;
         t  = (k < 2) ? tlo5_ff : thi5_ff;
         av = COORD_BITS'(v[DIFF_BITS-1] ? -v : v);
         at = (PROJ_BITS-1)'(t[PROJ_BITS-1] ? -t : t);
         map_in[k].neg  = v[DIFF_BITS-1] ^ t[PROJ_BITS-1];
         map_in[k].s    = s;
         map_in[k].prod = PROD_BITS'(av) * PROD_BITS'(at);
         map_in[k].len  = len5_ff;
      end
   end

   for (genvar g = 0; g < 4; g++) begin : g_map
      csov_map u_map (
         .clock  (clock),
         .map_in (map6_ff[g]),
         .coord  (coord[g])
      );
   end

   always_comb begin
      rsp_in.overlaps = odly_ff[MAP_LAT-1];
      if (odly_ff[MAP_LAT-1]) begin
         rsp_in.overlap_start_x = coord[0];
         rsp_in.overlap_start_y = coord[1];
         rsp_in.overlap_end_x   = coord[2];
         rsp_in.overlap_end_y   = coord[3];
      end else begin
         rsp_in.overlap_start_x = '0;
         rsp_in.overlap_start_y = '0;
         rsp_in.overlap_end_x   = '0;
         rsp_in.overlap_end_y   = '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // a result without overlap carries zero coordinates
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.overlaps |->
         rsp_item.overlap_start_x == '0 && rsp_item.overlap_start_y == '0 &&
         rsp_item.overlap_end_x == '0 && rsp_item.overlap_end_y == '0)
      else $error("non-overlap item with nonzero coordinates");

   // reset empties the pipe
   assert property (@(posedge clock) reset |=> !rsp_valid && busy)
      else $error("item left in pipe after reset");

   // busy never stays high outside reset recovery
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> !busy)
      else $error("busy raised without reset");

   // the output valid tracks the stage-one valid by the fixed latency
   assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> ##(PIPE_LAT - 1) (rsp_valid || $past(reset, PIPE_LAT - 2) || reset))
      else $error("item lost in pipe");

endmodule
`default_nettype wire

// ===== tb/sv/collinear_segment_overlap_tb.sv =====
// testbench for collinear_segment_overlap: random and directed segment triples, scoreboarded
`default_nettype none
module collinear_segment_overlap_tb;
   import csov_pkg::*;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   seg_req_type req_item;
   logic        rsp_valid;
   seg_rsp_type rsp_item;

   collinear_segment_overlap dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // floor((s + v*t/len) * 2^FRAC_BITS), clipped to the output range
   function automatic logic signed [OUT_BITS-1:0] map_point(longint s, longint v, longint t,
                                                            longint len);
      longint unsigned num, quo, rmd;
      longint val, hi_lim, lo_lim;
      bit neg;
      neg = ((v < 0) != (t < 0)) && v != 0 && t != 0;
      num = longint'(v < 0 ? -v : v) * longint'(t < 0 ? -t : t);
      num = num << FRAC_BITS;
      quo = num / longint'(len);
      rmd = num % longint'(len);
      val = neg ? -longint'(quo + (rmd != 0)) : longint'(quo);
      val += s * (longint'(1) << FRAC_BITS);
      hi_lim = (longint'(1) << (OUT_BITS - 1)) - 1;
      lo_lim = -hi_lim - 1;
      if (val > hi_lim) val = hi_lim;
      if (val < lo_lim) val = lo_lim;
      return val[OUT_BITS-1:0];
   endfunction

   function automatic seg_rsp_type overlap_of(seg_req_type r);
      seg_rsp_type o;
      longint sx, sy, vx, vy, len, lo1, hi1, lo2, hi2, tlo, thi;
      longint proj[4];
      o = '0;
      sx = longint'(r.seg_start_x);
      sy = longint'(r.seg_start_y);
      vx = longint'(r.seg_end_x) - sx;
      vy = longint'(r.seg_end_y) - sy;
      len = vx * vx + vy * vy;
      if (len == 0) return o;
      proj[0] = (longint'(r.first_part_start_x) - sx) * vx
              + (longint'(r.first_part_start_y) - sy) * vy;
      proj[1] = (longint'(r.first_part_end_x) - sx) * vx
              + (longint'(r.first_part_end_y) - sy) * vy;
      proj[2] = (longint'(r.second_part_start_x) - sx) * vx
              + (longint'(r.second_part_start_y) - sy) * vy;
      proj[3] = (longint'(r.second_part_end_x) - sx) * vx
              + (longint'(r.second_part_end_y) - sy) * vy;
      lo1 = proj[0] < proj[1] ? proj[0] : proj[1];
      hi1 = proj[0] < proj[1] ? proj[1] : proj[0];
      lo2 = proj[2] < proj[3] ? proj[2] : proj[3];
      hi2 = proj[2] < proj[3] ? proj[3] : proj[2];
      // touching ends count as no overlap
      if (lo1 >= hi2 || hi1 <= lo2) return o;
      tlo = lo1 > lo2 ? lo1 : lo2;
      thi = hi1 < hi2 ? hi1 : hi2;
      o.overlaps = 1'b1;
      o.overlap_start_x = map_point(sx, vx, tlo, len);
      o.overlap_start_y = map_point(sy, vy, tlo, len);
      o.overlap_end_x = map_point(sx, vx, thi, len);
      o.overlap_end_y = map_point(sy, vy, thi, len);
      return o;
   endfunction

   class overlap_scoreboard;
      seg_rsp_type pending[$];
      int errors = 0;
      int results = 0;
      int hits = 0;

      task report(string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      function void note(seg_req_type r);
         pending.push_back(overlap_of(r));
      endfunction

      task check(seg_rsp_type got);
         seg_rsp_type want;
         results++;
         if (got.overlaps) hits++;
         if (pending.size() == 0) begin
            report($sformatf("unexpected result %h", got));
            return;
         end
         want = pending.pop_front();
         if (got.overlaps !== want.overlaps)
            report($sformatf("overlaps got %b want %b", got.overlaps, want.overlaps));
         if (got.overlap_start_x !== want.overlap_start_x)
            report($sformatf("start_x got %0d want %0d", got.overlap_start_x,
                             want.overlap_start_x));
         if (got.overlap_start_y !== want.overlap_start_y)
            report($sformatf("start_y got %0d want %0d", got.overlap_start_y,
                             want.overlap_start_y));
         if (got.overlap_end_x !== want.overlap_end_x)
            report($sformatf("end_x got %0d want %0d", got.overlap_end_x,
                             want.overlap_end_x));
         if (got.overlap_end_y !== want.overlap_end_y)
            report($sformatf("end_y got %0d want %0d", got.overlap_end_y,
                             want.overlap_end_y));
      endtask
   endclass

   overlap_scoreboard sb = new();
   int sent = 0;
   bit steady = 0;

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check(rsp_item);
   end

   // called at a falling edge; returns at the falling edge after acceptance or, when not steady, after a random gap
   task send_item(seg_req_type r);
      int gap;
      start = 1'b1;
      req_item = r;
      while (busy) @(negedge clock);
      @(posedge clock);
      sb.note(r);
      sent++;
      @(negedge clock);
      if (!steady) begin
         gap = $urandom_range(0, 9);
         gap = gap < 7 ? 0 : (gap < 9 ? $urandom_range(1, 3) : $urandom_range(10, 30));
         if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   function automatic seg_req_type full_random();
      seg_req_type r;
      r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      return r;
   endfunction

   // parts placed along the reference line at random multiples of its step, two ends sometimes nudged off it
   function automatic seg_req_type on_line();
      seg_req_type r;
      int bx, by, dx, dy, k[6], off, ke;
      bx = $signed($urandom_range(0, 40000)) - 20000;
      by = $signed($urandom_range(0, 40000)) - 20000;
      dx = $signed($urandom_range(0, 80)) - 40;
      dy = $signed($urandom_range(0, 80)) - 40;
      foreach (k[i]) k[i] = $signed($urandom_range(0, 300)) - 150;
      off = $urandom_range(0, 3) == 0;
      // sometimes make the parts share an end exactly
      ke = $urandom_range(0, 4) == 0 ? k[3] : k[5];
      r.seg_start_x = COORD_BITS'(bx + dx * k[0]);
      r.seg_start_y = COORD_BITS'(by + dy * k[0]);
      r.seg_end_x = COORD_BITS'(bx + dx * k[1]);
      r.seg_end_y = COORD_BITS'(by + dy * k[1]);
      r.first_part_start_x =
         COORD_BITS'(bx + dx * k[2] + (off ? $signed($urandom_range(0, 6)) - 3 : 0));
      r.first_part_start_y = COORD_BITS'(by + dy * k[2]);
      r.first_part_end_x = COORD_BITS'(bx + dx * k[3]);
      r.first_part_end_y = COORD_BITS'(by + dy * k[3]);
      r.second_part_start_x = COORD_BITS'(bx + dx * k[4]);
      r.second_part_start_y =
         COORD_BITS'(by + dy * k[4] + (off ? $signed($urandom_range(0, 6)) - 3 : 0));
      r.second_part_end_x = COORD_BITS'(bx + dx * ke);
      r.second_part_end_y = COORD_BITS'(by + dy * ke);
      return r;
   endfunction

   function automatic seg_req_type pack12(int a, int b, int c, int d, int e, int f,
                                          int g, int h, int i, int j, int k, int l);
      seg_req_type r;
      r = {a[15:0], b[15:0], c[15:0], d[15:0], e[15:0], f[15:0],
           g[15:0], h[15:0], i[15:0], j[15:0], k[15:0], l[15:0]};
      return r;
   endfunction

   initial begin
      seg_req_type r;
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // plain overlap on the x axis
      send_item(pack12(0, 0, 10, 0, 1, 0, 6, 0, 4, 0, 9, 0));
      // zero-length reference
      send_item(pack12(5, 5, 5, 5, 1, 0, 6, 0, 4, 0, 9, 0));
      // touching ends
      send_item(pack12(0, 0, 10, 0, 1, 0, 4, 0, 4, 0, 9, 0));
      // disjoint, reversed endpoints
      send_item(pack12(0, 0, 10, 0, 3, 0, 1, 0, 9, 0, 6, 0));
      // negative direction, fractional result
      send_item(pack12(0, 0, -3, -7, 1, 2, -5, -9, -2, -3, 4, 4));
      // full-range extremes
      send_item(pack12(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767,
                       -32768, -32768, 32767, 32767));
      send_item(pack12(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767,
                       -32768, -32768, 32767, 32767));
      send_item(pack12(-32768, 0, -32767, 0, 32767, 0, -32768, 0, 32767, 1, -32768, -1));
      send_item(pack12(-32768, -32768, -32767, -32767, 32767, 32767, -32768, -32768,
                       32767, -32768, -32768, 32767));
      send_item(pack12(32767, 0, 32766, 0, -32768, 0, 32767, 0, -32768, 32767, 0, 0));
      send_item(pack12(0, 0, 1, 1, 0, 1, 1, 0, 1, 0, 0, 1));
      // one part degenerate to a point
      send_item(pack12(0, 0, 10, 0, 5, 0, 5, 0, 0, 0, 10, 0));
      for (int i = 0; i < 8; i++) send_item(full_random());

      // hold off until the pipe drains
      start = 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);

      for (int i = 0; i < 1450; i++) begin
         if (i % 200 == 0) steady = $urandom_range(0, 2) == 0;
         r = $urandom_range(0, 9) < 7 ? on_line() : full_random();
         if ($urandom_range(0, 30) == 0) begin
            r.seg_end_x = r.seg_start_x;
            r.seg_end_y = r.seg_start_y;
         end
         send_item(r);
      end
      start = 1'b0;

      while (sb.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      $display("ran %0d segment triples, %0d results checked, %0d with overlap",
               sent, sb.results, sb.hits);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("** collinear_segment_overlap: PASSED **");
      else
         $display("** collinear_segment_overlap: FAILED **");
      $finish;
   end

   initial begin
      #4000000;
      $display("timeout");
      $display("** collinear_segment_overlap: FAILED **");
      $finish;
   end

endmodule
`default_nettype wire

// ===== collinear_segment_overlap.f =====
rtl/core/csov_pkg.sv
rtl/core/csov_map.sv
rtl/core/collinear_segment_overlap.sv
tb/sv/collinear_segment_overlap_tb.sv
